// File: rtl/core/assert_macros.svh
// Assertion macros for the checker in rff_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is held.
`define RFF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rff assertion failed");

// Check a property on the rising clock edge, also during reset.
`define RFF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rff assertion failed");

`endif

// File: rtl/core/rff_pkg.sv
`default_nettype none
package rff_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_RADIUS = 2'd1;
    localparam logic [1:0] CFG_SCALE  = 2'd2;

    // Falloff modes (the unused code acts as constant)
    localparam logic [1:0] MODE_CONST  = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_SQUARE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [1:0]  MODE_RST   = MODE_CONST;
    localparam logic [30:0] RADIUS_RST = 31'd327680;
    localparam logic [15:0] SCALE_RST  = 16'd256;

    // Sideband through the square root stages
    typedef struct packed {
        logic             kill;
        logic [2:0]       neg;
        logic [31:0]      fm;
        logic [31:0]      r;
        logic [2:0][31:0] a;
    } t_sq_side;

    // Sideband through the first divider
    typedef struct packed {
        logic             kill;
        logic [2:0]       neg;
        logic [31:0]      fm;
        logic [31:0]      mg;
        logic [31:0]      l;
        logic [2:0][31:0] a;
    } t_d1_side;

    // Sideband through the second divider
    typedef struct packed {
        logic             kill;
        logic [2:0]       neg;
        logic [31:0]      fm;
        logic [31:0]      q1;
        logic [31:0]      l;
        logic [2:0][31:0] a;
    } t_d2_side;

    // Sideband through the component dividers
    typedef struct packed {
        logic       kill;
        logic [2:0] neg;
    } t_d3_side;

endpackage
`default_nettype wire

// File: rtl/core/rff_front.sv
`default_nettype none
module rff_front import rff_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_valid,
    output      logic               o_ready,
    input  wire logic               i_step_active,
    input  wire logic signed [31:0] i_force_value,
    input  wire logic signed [31:0] i_trigger_x,
    input  wire logic signed [31:0] i_trigger_y,
    input  wire logic signed [31:0] i_trigger_z,
    input  wire logic signed [31:0] i_target_x,
    input  wire logic signed [31:0] i_target_y,
    input  wire logic signed [31:0] i_target_z,
    input  wire logic        [30:0] i_body_extent,
    input  wire logic               i_has_mass,
    input  wire logic        [30:0] i_base_radius,
    output      logic               o_valid,
    output      logic [1:0][63:0]   o_rad,
    output      t_sq_side           o_side
);

    // Stage 1: offsets, reach, force magnitude
    logic                      r_v1;
    logic signed [2:0][32:0]   r_d1;
    logic        [31:0]        r_r1;
    logic        [31:0]        r_fm1;
    logic                      r_fneg1;
    logic                      r_kill1;

    // Stage 2: absolute offsets, per-axis reach test
    logic                      r_v2;
    logic        [2:0][31:0]   r_a2;
    logic        [2:0]         r_neg2;
    logic                      r_dzneg2;
    logic        [31:0]        r_r2;
    logic        [31:0]        r_fm2;
    logic                      r_kill2;

    // Stage 3: squares
    logic                      r_v3;
    logic        [2:0][63:0]   r_sq3;
    logic        [63:0]        r_rr3;
    logic                      r_dzneg3;
    t_sq_side                  r_side3;

    // Stage 4: sums and reach test
    logic                      r_v4;
    logic        [1:0][63:0]   r_rad4;
    t_sq_side                  r_side4;

    logic        [2:0][32:0]   w_abs;
    logic                      w_far;
    logic        [65:0]        w_s;
    logic        [65:0]        w_sc;
    logic        [2:0][31:0]   w_ac;

    // Accept a word while stage 1 is empty or moving on
    assign o_ready = !r_v1 || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_d1[0] <= {i_target_x[31], i_target_x} - {i_trigger_x[31], i_trigger_x};
            r_d1[1] <= {i_target_y[31], i_target_y} - {i_trigger_y[31], i_trigger_y};
            r_d1[2] <= {i_target_z[31], i_target_z} - {i_trigger_z[31], i_trigger_z};
            r_r1    <= {1'b0, i_base_radius} + {1'b0, i_body_extent};
            r_fm1   <= i_force_value[31] ? 32'(-i_force_value) : 32'(i_force_value);
            r_fneg1 <= i_force_value[31];
            r_kill1 <= !i_step_active || (i_force_value == '0) || !i_has_mass;
        end
    end

    // Form magnitudes and test each axis against the reach
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = r_d1[i][32] ? 33'(-r_d1[i]) : 33'(r_d1[i]);
        end
        w_far = (w_abs[0] > {1'b0, r_r1}) || (w_abs[1] > {1'b0, r_r1})
             || (w_abs[2] > {1'b0, r_r1});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_a2[i]   <= w_abs[i][31:0];
                r_neg2[i] <= r_d1[i][32] != r_fneg1;
            end
            r_dzneg2 <= r_d1[2][32];
            r_r2     <= r_r1;
            r_fm2    <= r_fm1;
            r_kill2  <= r_kill1 || w_far;
        end
    end

    // Clamp a negative Z offset for the direction vector
    assign w_ac[0] = r_a2[0];
    assign w_ac[1] = r_a2[1];
    assign w_ac[2] = r_dzneg2 ? '0 : r_a2[2];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_sq3[i] <= 64'(r_a2[i]) * 64'(r_a2[i]);
            end
            r_rr3         <= 64'(r_r2) * 64'(r_r2);
            r_dzneg3      <= r_dzneg2;
            r_side3.kill  <= r_kill2;
            r_side3.neg   <= r_neg2;
            r_side3.fm    <= r_fm2;
            r_side3.r     <= r_r2;
            r_side3.a     <= w_ac;
        end
    end

    assign w_s  = 66'(r_sq3[0]) + 66'(r_sq3[1]) + 66'(r_sq3[2]);
    assign w_sc = 66'(r_sq3[0]) + 66'(r_sq3[1]) + (r_dzneg3 ? '0 : 66'(r_sq3[2]));

    // Drop zero offsets and bodies beyond reach
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rad4[0]    <= w_s[63:0];
            r_rad4[1]    <= w_sc[63:0];
            r_side4.neg  <= r_side3.neg;
            r_side4.fm   <= r_side3.fm;
            r_side4.r    <= r_side3.r;
            r_side4.a    <= r_side3.a;
            r_side4.kill <= r_side3.kill || (w_s == '0) || (w_s > 66'(r_rr3))
                         || (w_sc == '0);
        end
    end

    assign o_valid = r_v4;
    assign o_rad   = r_rad4;
    assign o_side  = r_side4;

endmodule
`default_nettype wire

// File: rtl/core/rff_sqrt.sv
`default_nettype none
module rff_sqrt import rff_pkg::*; #(
    parameter int LANES = 2,
    parameter int RW    = 32,
    parameter int SW    = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_valid,
    input  wire logic [LANES-1:0][2*RW-1:0]  i_rad,
    input  wire logic [SW-1:0]               i_side,
    output      logic                        o_valid,
    output      logic [LANES-1:0][RW-1:0]    o_root,
    output      logic [SW-1:0]               o_side
);

    localparam int W = 2 * RW;

    logic [LANES-1:0][W-1:0]  w_rem  [0:RW];
    logic [LANES-1:0][RW-1:0] w_root [0:RW];
    logic                     w_v    [0:RW];
    logic [SW-1:0]            w_side [0:RW];

    assign w_rem[0]  = i_rad;
    assign w_root[0] = '0;
    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;

    // One root bit per stage, most significant first
    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;

        logic [LANES-1:0][W-1:0]  n_rem;
        logic [LANES-1:0][RW-1:0] n_root;
        logic [LANES-1:0][W-1:0]  r_rem;
        logic [LANES-1:0][RW-1:0] r_root;
        logic                     r_v;
        logic [SW-1:0]            r_side;

        for (genvar j = 0; j < LANES; j++) begin : g_lane
            logic [W-1:0] w_trial;
            logic         w_ge;

            // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
            assign w_trial = ({{RW{1'b0}}, w_root[k][j]} << (B + 1))
                           | ({{(W-1){1'b0}}, 1'b1} << (2 * B));
            assign w_ge      = w_rem[k][j] >= w_trial;
            assign n_rem[j]  = w_ge ? w_rem[k][j] - w_trial : w_rem[k][j];
            assign n_root[j] = w_root[k][j]
                             | (w_ge ? ({{(RW-1){1'b0}}, 1'b1} << B) : '0);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_adv) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_side <= w_side[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[RW];
    assign o_root  = w_root[RW];
    assign o_side  = w_side[RW];

endmodule
`default_nettype wire

// File: rtl/core/rff_div.sv
`default_nettype none
module rff_div import rff_pkg::*; #(
    parameter int LANES = 1,
    parameter int NW    = 64,
    parameter int QW    = 32,
    parameter int SW    = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_valid,
    input  wire logic [LANES-1:0][NW-1:0]    i_num,
    input  wire logic [NW-QW-1:0]            i_den,
    input  wire logic [SW-1:0]               i_side,
    output      logic                        o_valid,
    output      logic [LANES-1:0][QW-1:0]    o_quo,
    output      logic [NW-QW-1:0]            o_den,
    output      logic [SW-1:0]               o_side
);

    // The quotient fits QW bits, so the upper numerator part is below the divisor
    localparam int DW = NW - QW;

    logic [LANES-1:0][DW-1:0] w_rem  [0:QW];
    logic [LANES-1:0][QW-1:0] w_nq   [0:QW];
    logic [DW-1:0]            w_den  [0:QW];
    logic                     w_v    [0:QW];
    logic [SW-1:0]            w_side [0:QW];

    for (genvar j = 0; j < LANES; j++) begin : g_init
        assign w_rem[0][j] = i_num[j][NW-1:QW];
        assign w_nq[0][j]  = i_num[j][QW-1:0];
    end
    assign w_den[0]  = i_den;
    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;

    // Restoring division: shift in one numerator bit, take out one quotient bit
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [LANES-1:0][DW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_nq;
        logic [LANES-1:0][DW-1:0] r_rem;
        logic [LANES-1:0][QW-1:0] r_nq;
        logic [DW-1:0]            r_den;
        logic                     r_v;
        logic [SW-1:0]            r_side;

        for (genvar j = 0; j < LANES; j++) begin : g_lane
            logic [DW:0] w_t;
            logic [DW:0] w_diff;
            logic        w_ge;

            assign w_t      = {w_rem[k][j], w_nq[k][j][QW-1]};
            assign w_diff   = w_t - {1'b0, w_den[k]};
            assign w_ge     = w_t >= {1'b0, w_den[k]};
            assign n_rem[j] = w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
            assign n_nq[j]  = {w_nq[k][j][QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_adv) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem  <= n_rem;
                r_nq   <= n_nq;
                r_den  <= w_den[k];
                r_side <= w_side[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_nq[k+1]   = r_nq;
        assign w_den[k+1]  = r_den;
        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[QW];
    assign o_quo   = w_nq[QW];
    assign o_den   = w_den[QW];
    assign o_side  = w_side[QW];

endmodule
`default_nettype wire

// File: rtl/core/radial_force_falloff.sv
// Radial force falloff: one body of an explosion field per word in, one
// force vector per word out.
// Input channel: i_in_valid / o_in_ready with the body fields (step flag,
// force, trigger and target positions, body extent, mass flag).
// Output channel: o_out_valid / i_out_ready with force_x/y/z (signed Q16.16,
// saturated) and apply; a word that gets no force comes out as a zero vector
// with apply low.
// Configuration: i_cfg_wen writes i_cfg_wdata into the register at
// i_cfg_addr (0 falloff mode, 1 base radius, 2 force scale); write only
// while the block is empty.
// One word is accepted per cycle while the receiver does not stall. The depth is
// set by the two 32-stage square roots (run side by side) and the three
// 32/33-stage restoring dividers in series.
// Reset empties the pipeline and restores mode constant, radius 5.0, scale 1.0.
// When the receiver stalls, the whole pipeline holds; the entry stage still
// takes one more word if it is empty, so nothing is lost or repeated.
`default_nettype none
module radial_force_falloff import rff_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wen,
    input  wire logic        [1:0]  i_cfg_addr,
    input  wire logic        [30:0] i_cfg_wdata,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic               i_step_active,
    input  wire logic signed [31:0] i_force_value,
    input  wire logic signed [31:0] i_trigger_x,
    input  wire logic signed [31:0] i_trigger_y,
    input  wire logic signed [31:0] i_trigger_z,
    input  wire logic signed [31:0] i_target_x,
    input  wire logic signed [31:0] i_target_y,
    input  wire logic signed [31:0] i_target_z,
    input  wire logic        [30:0] i_body_extent,
    input  wire logic               i_has_mass,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic signed [31:0] o_force_x,
    output      logic signed [31:0] o_force_y,
    output      logic signed [31:0] o_force_z,
    output      logic               o_apply
);

    logic [1:0]        r_mode;
    logic [30:0]       r_radius;
    logic [15:0]       r_scale;

    logic              w_adv;

    logic              w_sq_in_v;
    logic [1:0][63:0]  w_sq_rad;
    t_sq_side          w_sq_in_side;
    logic              w_sq_v;
    logic [1:0][31:0]  w_sq_root;
    t_sq_side          w_sq_side;

    logic              r_p1_v;
    logic [0:0][63:0]  r_p1_num;
    logic [31:0]       r_p1_den;
    t_d1_side          r_p1_side;
    logic              w_d1_v;
    logic [0:0][31:0]  w_d1_quo;
    logic [31:0]       w_d1_den;
    t_d1_side          w_d1_side;

    logic              r_p2_v;
    logic [0:0][64:0]  r_p2_num;
    logic [31:0]       r_p2_den;
    t_d2_side          r_p2_side;
    logic              w_d2_v;
    logic [0:0][32:0]  w_d2_quo;
    logic [31:0]       w_d2_den;
    t_d2_side          w_d2_side;

    logic [32:0]       w_rf;
    logic              r_p3_v;
    logic [2:0][64:0]  r_p3_num;
    logic [31:0]       r_p3_den;
    t_d3_side          r_p3_side;
    logic              w_d3_v;
    logic [2:0][32:0]  w_d3_quo;
    logic [31:0]       w_d3_den;
    t_d3_side          w_d3_side;

    logic              w_any;
    logic [2:0][31:0]  w_sat;
    logic              r_out_v;
    logic [2:0][31:0]  r_force;
    logic              r_apply;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RST;
            r_radius <= RADIUS_RST;
            r_scale  <= SCALE_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                CFG_MODE:   r_mode   <= i_cfg_wdata[1:0];
                CFG_RADIUS: r_radius <= i_cfg_wdata;
                CFG_SCALE:  r_scale  <= i_cfg_wdata[15:0];
                default:    ;
            endcase
        end
    end

    // Advance the pipeline unless a finished word waits
    assign w_adv = !r_out_v || i_out_ready;

    rff_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_step_active (i_step_active),
        .i_force_value (i_force_value),
        .i_trigger_x   (i_trigger_x),
        .i_trigger_y   (i_trigger_y),
        .i_trigger_z   (i_trigger_z),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_target_z    (i_target_z),
        .i_body_extent (i_body_extent),
        .i_has_mass    (i_has_mass),
        .i_base_radius (r_radius),
        .o_valid       (w_sq_in_v),
        .o_rad         (w_sq_rad),
        .o_side        (w_sq_in_side)
    );

    // Distance and direction length side by side
    rff_sqrt #(.LANES(2), .RW(32), .SW($bits(t_sq_side))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_sq_in_v),
        .i_rad   (w_sq_rad),
        .i_side  (w_sq_in_side),
        .o_valid (w_sq_v),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // Linear weight numerator: |f| * (R - mag)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_adv) begin
            r_p1_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_num[0]    <= 64'(w_sq_side.fm) * 64'(w_sq_side.r - w_sq_root[0]);
            r_p1_den       <= w_sq_side.r;
            r_p1_side.kill <= w_sq_side.kill;
            r_p1_side.neg  <= w_sq_side.neg;
            r_p1_side.fm   <= w_sq_side.fm;
            r_p1_side.mg   <= w_sq_root[0];
            r_p1_side.l    <= w_sq_root[1];
            r_p1_side.a    <= w_sq_side.a;
        end
    end

    rff_div #(.LANES(1), .NW(64), .QW(32), .SW($bits(t_d1_side))) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_p1_v),
        .i_num   (r_p1_num),
        .i_den   (r_p1_den),
        .i_side  (r_p1_side),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_quo),
        .o_den   (w_d1_den),
        .o_side  (w_d1_side)
    );

    // Square weight numerator: t * (R + mag)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (w_adv) begin
            r_p2_v <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p2_num[0]    <= 65'(w_d1_quo[0])
                            * 65'({1'b0, w_d1_den} + {1'b0, w_d1_side.mg});
            r_p2_den       <= w_d1_den;
            r_p2_side.kill <= w_d1_side.kill;
            r_p2_side.neg  <= w_d1_side.neg;
            r_p2_side.fm   <= w_d1_side.fm;
            r_p2_side.q1   <= w_d1_quo[0];
            r_p2_side.l    <= w_d1_side.l;
            r_p2_side.a    <= w_d1_side.a;
        end
    end

    rff_div #(.LANES(1), .NW(65), .QW(33), .SW($bits(t_d2_side))) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_p2_v),
        .i_num   (r_p2_num),
        .i_den   (r_p2_den),
        .i_side  (r_p2_side),
        .o_valid (w_d2_v),
        .o_quo   (w_d2_quo),
        .o_den   (w_d2_den),
        .o_side  (w_d2_side)
    );

    // Pick the weighted force by falloff mode
    always_comb begin
        case (r_mode)
            MODE_LINEAR: w_rf = {1'b0, w_d2_side.q1};
            MODE_SQUARE: w_rf = w_d2_quo[0];
            default:     w_rf = {1'b0, w_d2_side.fm};
        endcase
    end

    // Component numerators: |d_i| * rf
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else if (w_adv) begin
            r_p3_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_p3_num[i] <= 65'(w_d2_side.a[i]) * 65'(w_rf);
            end
            r_p3_den       <= w_d2_side.l;
            r_p3_side.kill <= w_d2_side.kill || (w_d2_den == '0);
            r_p3_side.neg  <= w_d2_side.neg;
        end
    end

    rff_div #(.LANES(3), .NW(65), .QW(33), .SW($bits(t_d3_side))) u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_p3_v),
        .i_num   (r_p3_num),
        .i_den   (r_p3_den),
        .i_side  (r_p3_side),
        .o_valid (w_d3_v),
        .o_quo   (w_d3_quo),
        .o_den   (w_d3_den),
        .o_side  (w_d3_side)
    );

    // Apply force scale, restore sign, saturate
    assign w_any = (w_d3_quo[0] != '0) || (w_d3_quo[1] != '0) || (w_d3_quo[2] != '0);

    for (genvar i = 0; i < 3; i++) begin : g_sat
        logic [48:0] w_prod;
        logic [40:0] w_m;
        logic [31:0] w_neg_mag;

        assign w_prod    = 49'(w_d3_quo[i]) * 49'(r_scale);
        assign w_m       = w_prod[48:8];
        assign w_neg_mag = (w_m > 41'h0_8000_0000) ? 32'h8000_0000 : w_m[31:0];
        assign w_sat[i]  = w_d3_side.neg[i] ? 32'(~w_neg_mag + 32'd1)
                         : ((w_m > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : w_m[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= w_d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_apply <= !w_d3_side.kill && w_any && (w_d3_den != '0);
            for (int i = 0; i < 3; i++) begin
                r_force[i] <= (!w_d3_side.kill && w_any) ? w_sat[i] : '0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_force_x   = r_force[0];
    assign o_force_y   = r_force[1];
    assign o_force_z   = r_force[2];
    assign o_apply     = r_apply;

endmodule
`default_nettype wire

// File: rtl/core/rff_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rff_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_in_ready,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] o_force_x,
    input  wire logic signed [31:0] o_force_y,
    input  wire logic signed [31:0] o_force_z,
    input  wire logic               o_apply
);

    // A stalled result word stays put
    `RFF_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)

    // A word without force carries a zero vector
    `RFF_ASSERT(a_zero_when_idle, i_clk, i_rst_n, o_out_valid && !o_apply |-> o_force_x == 0 && o_force_y == 0 && o_force_z == 0)

    // With no result waiting the input side is open
    `RFF_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    // Reset empties the output stage
    `RFF_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind radial_force_falloff rff_checker u_rff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_force_x   (o_force_x),
    .o_force_y   (o_force_y),
    .o_force_z   (o_force_z),
    .o_apply     (o_apply)
);
`default_nettype wire

// File: verif/rff_force_checker.sv
`default_nettype none
module rff_force_checker import rff_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wen,
    input  wire logic        [1:0]  i_cfg_addr,
    input  wire logic        [30:0] i_cfg_wdata,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic               i_step_active,
    input  wire logic signed [31:0] i_force_value,
    input  wire logic signed [31:0] i_trigger_x,
    input  wire logic signed [31:0] i_trigger_y,
    input  wire logic signed [31:0] i_trigger_z,
    input  wire logic signed [31:0] i_target_x,
    input  wire logic signed [31:0] i_target_y,
    input  wire logic signed [31:0] i_target_z,
    input  wire logic        [30:0] i_body_extent,
    input  wire logic               i_has_mass,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] i_force_x,
    input  wire logic signed [31:0] i_force_y,
    input  wire logic signed [31:0] i_force_z,
    input  wire logic               i_apply,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic               apply;
    } force_word_t;

    typedef longint unsigned u64_t;

    logic [1:0]  mode_q;
    logic [30:0] radius_q;
    logic [15:0] scale_q;

    force_word_t expected_forces[$];

    // Floor square root, bit by bit
    function automatic u64_t root_floor(input u64_t n);
        u64_t rt;
        u64_t bt;
        rt = 0;
        bt = 64'h4000_0000_0000_0000;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (n >= rt + bt) begin
                n  = n - (rt + bt);
                rt = (rt >> 1) + bt;
            end else begin
                rt = rt >> 1;
            end
            bt = bt >> 2;
        end
        return rt;
    endfunction

    // Clamp a magnitude with sign into signed 32 bits
    function automatic logic [31:0] clamp_signed(input u64_t m, input logic neg);
        if (neg) begin
            if (m > 64'h8000_0000) m = 64'h8000_0000;
            return 32'd0 - m[31:0];
        end
        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
        return m[31:0];
    endfunction

    function automatic force_word_t predict_force(
        input logic               step,
        input logic signed [31:0] fv,
        input logic [2:0][31:0]   trig,
        input logic [2:0][31:0]   targ,
        input logic [30:0]        ext,
        input logic               mass
    );
        force_word_t w;
        longint      d[3];
        u64_t        a[3];
        u64_t        sq[3];
        u64_t        s, r, mg, fm, rf, sc, l, m;
        u64_t        comp[3];
        logic        fneg, any_nz;
        w      = '0;
        any_nz = 1'b0;
        if (!step || fv == 0 || !mass) return w;
        r = u64_t'(radius_q) + u64_t'(ext);
        for (int i = 0; i < 3; i++) begin
            d[i]  = longint'($signed(targ[i])) - longint'($signed(trig[i]));
            a[i]  = d[i] < 0 ? u64_t'(-d[i]) : u64_t'(d[i]);
            if (a[i] > r) return w;
            sq[i] = a[i] * a[i];
        end
        s = sq[0] + sq[1];
        if (s < sq[0]) return w;
        s = s + sq[2];
        if (s < sq[2]) return w;
        if (s == 0 || s > r * r) return w;
        mg   = root_floor(s);
        fneg = fv < 0;
        fm   = fneg ? u64_t'(-longint'(fv)) : u64_t'(longint'(fv));
        // Weight the force by distance over reach
        if (mode_q == MODE_LINEAR) begin
            rf = fm * (r - mg) / r;
        end else if (mode_q == MODE_SQUARE) begin
            rf = fm * (r - mg) / r;
            rf = rf * (r + mg) / r;
        end else begin
            rf = fm;
        end
        // Drop a downward offset before normalizing
        if (d[2] < 0) begin
            d[2] = 0;
            a[2] = 0;
            sq[2] = 0;
        end
        sc = sq[0] + sq[1] + sq[2];
        if (sc == 0) return w;
        l = root_floor(sc);
        for (int i = 0; i < 3; i++) begin
            comp[i] = a[i] * rf / l;
            if (comp[i] != 0) any_nz = 1'b1;
        end
        if (!any_nz) return w;
        m    = (comp[0] * u64_t'(scale_q)) >> 8;
        w.fx = clamp_signed(m, (d[0] < 0) != fneg);
        m    = (comp[1] * u64_t'(scale_q)) >> 8;
        w.fy = clamp_signed(m, (d[1] < 0) != fneg);
        m    = (comp[2] * u64_t'(scale_q)) >> 8;
        w.fz = clamp_signed(m, (d[2] < 0) != fneg);
        w.apply = 1'b1;
        return w;
    endfunction

    assign o_pending = expected_forces.size();

    // Track registers, queue predictions, compare results
    always @(posedge i_clk) begin
        force_word_t exp_w;
        if (!i_rst_n) begin
            mode_q       <= MODE_RST;
            radius_q     <= RADIUS_RST;
            scale_q      <= SCALE_RST;
            o_fail_count <= 0;
            expected_forces.delete();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_addr)
                    CFG_MODE:   mode_q   <= i_cfg_wdata[1:0];
                    CFG_RADIUS: radius_q <= i_cfg_wdata;
                    CFG_SCALE:  scale_q  <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_forces.push_back(predict_force(i_step_active, i_force_value,
                    {i_trigger_z, i_trigger_y, i_trigger_x},
                    {i_target_z, i_target_y, i_target_x}, i_body_extent, i_has_mass));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_forces.size() == 0) begin
                    $display("%0t: unexpected word fx=%0d fy=%0d fz=%0d apply=%0d",
                             $time, i_force_x, i_force_y, i_force_z, i_apply);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_forces.pop_front();
                    if (exp_w != {i_force_x, i_force_y, i_force_z, i_apply}) begin
                        $display("%0t: mismatch exp fx=%0d fy=%0d fz=%0d apply=%0d",
                                 $time, exp_w.fx, exp_w.fy, exp_w.fz, exp_w.apply);
                        $display("%0t:          got fx=%0d fy=%0d fz=%0d apply=%0d",
                                 $time, i_force_x, i_force_y, i_force_z, i_apply);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: verif/radial_force_falloff_tb.sv
`default_nettype none
module radial_force_falloff_tb import rff_pkg::*;;

    logic               clk;
    logic               rst_n;
    logic               cfg_wen;
    logic        [1:0]  cfg_addr;
    logic        [30:0] cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic               step_active;
    logic signed [31:0] force_value;
    logic signed [31:0] trig_x, trig_y, trig_z;
    logic signed [31:0] targ_x, targ_y, targ_z;
    logic        [30:0] body_extent;
    logic               has_mass;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] force_x, force_y, force_z;
    logic               apply;
    logic               in_taken;
    int                 fail_count;
    int                 pending;
    int                 tx_idle_pct;
    int                 rx_idle_pct;

    radial_force_falloff DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wen(cfg_wen), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_step_active(step_active), .i_force_value(force_value),
        .i_trigger_x(trig_x), .i_trigger_y(trig_y), .i_trigger_z(trig_z),
        .i_target_x(targ_x), .i_target_y(targ_y), .i_target_z(targ_z),
        .i_body_extent(body_extent), .i_has_mass(has_mass),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_force_x(force_x), .o_force_y(force_y), .o_force_z(force_z), .o_apply(apply)
    );

    rff_force_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wen(cfg_wen), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_step_active(step_active), .i_force_value(force_value),
        .i_trigger_x(trig_x), .i_trigger_y(trig_y), .i_trigger_z(trig_z),
        .i_target_x(targ_x), .i_target_y(targ_y), .i_target_z(targ_z),
        .i_body_extent(body_extent), .i_has_mass(has_mass),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_force_x(force_x), .i_force_y(force_y), .i_force_z(force_z), .i_apply(apply),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Note each accepted input word for the driver
    always @(posedge clk) in_taken <= in_valid && in_ready;

    // Stall the receiver at random
    always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // Send one body word, idling the sender at random before it
    task automatic send_body(input logic step, input logic signed [31:0] fv,
                             input logic signed [31:0] tx, ty, tz, gx, gy, gz,
                             input logic [30:0] ext, input logic mass);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        step_active <= step;
        force_value <= fv;
        trig_x <= tx; trig_y <= ty; trig_z <= tz;
        targ_x <= gx; targ_y <= gy; targ_z <= gz;
        body_extent <= ext;
        has_mass    <= mass;
        do @(negedge clk); while (!in_taken);
    endtask

    // Hold off until the pipeline has drained
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_regs(input logic [1:0] mode, input logic [30:0] radius,
                              input logic [15:0] scale);
        cfg_wen <= 1'b1; cfg_addr <= CFG_MODE;   cfg_wdata <= 31'(mode);
        @(negedge clk);
        cfg_addr <= CFG_RADIUS; cfg_wdata <= radius;
        @(negedge clk);
        cfg_addr <= CFG_SCALE;  cfg_wdata <= 31'(scale);
        @(negedge clk);
        cfg_wen <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_force();
        logic signed [31:0] v;
        v = $urandom();
        return v >>> $urandom_range(0, 31);
    endfunction

    // Random body, mostly placed inside the reach of the field
    task automatic send_random_body(input logic [30:0] radius);
        logic signed [31:0] tx, ty, tz, gx, gy, gz;
        logic        [30:0] ext;
        longint unsigned    reach, lim;
        int                 kind;
        kind = $urandom_range(99);
        ext  = $urandom_range(3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 1 << 18));
        if (kind < 20) begin
            send_body(1'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), 31'($urandom()),
                      1'($urandom()));
        end else begin
            reach = longint'(radius) + longint'(ext);
            lim   = reach * $urandom_range(3, 6) / 8;
            tx = $signed($urandom()) >>> $urandom_range(1, 31);
            ty = $signed($urandom()) >>> $urandom_range(1, 31);
            tz = $signed($urandom()) >>> $urandom_range(1, 31);
            gx = tx + ($urandom_range(1) ? 1 : -1) * $signed(32'($urandom_range(0, 32'(lim))));
            gy = ty + ($urandom_range(1) ? 1 : -1) * $signed(32'($urandom_range(0, 32'(lim))));
            gz = tz + ($urandom_range(1) ? 1 : -1) * $signed(32'($urandom_range(0, 32'(lim))));
            send_body(kind < 95, rand_force(), tx, ty, tz, gx, gy, gz, ext, kind != 96);
        end
    endtask

    initial begin
        logic [1:0]  mode;
        logic [30:0] radius;
        logic [15:0] scale;
        rst_n = 1'b0; cfg_wen = 1'b0; cfg_addr = CFG_MODE; cfg_wdata = '0;
        in_valid = 1'b0; step_active = 1'b0; force_value = '0;
        trig_x = '0; trig_y = '0; trig_z = '0; targ_x = '0; targ_y = '0; targ_z = '0;
        body_extent = '0; has_mass = 1'b0; out_ready = 1'b0;
        tx_idle_pct = 12; rx_idle_pct = 79;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed bodies at reset settings: base radius 5.0
        send_body(1'b0, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 1'b1);
        send_body(1'b1, 0, 0, 0, 0, 32'sh10000, 0, 0, 0, 1'b1);
        send_body(1'b1, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 1'b0);
        send_body(1'b1, 32'sh10000, 5, 6, 7, 5, 6, 7, 0, 1'b1);
        send_body(1'b1, 32'sh10000, 0, 0, 0, 32'sh60000, 0, 0, 0, 1'b1);
        send_body(1'b1, 32'sh10000, 0, 0, 0, 32'sh40000, 32'sh40000, 0, 0, 1'b1);
        send_body(1'b1, 32'sh10000, 0, 0, 0, 0, 0, -32'sh20000, 0, 1'b1);
        send_body(1'b1, 32'sh7FFFFFFF, 0, 0, 0, 32'sh10000, -32'sh10000, 32'sh8000, 0, 1'b1);
        send_body(1'b1, 32'sh80000000, 0, 0, 0, -32'sh10000, 32'sh20000, -32'sh8000, 0, 1'b1);
        send_body(1'b1, 1, 0, 0, 0, 32'sh30000, 32'sh10, 32'sh1, 0, 1'b1);
        send_body(1'b1, 32'sh10000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 1'b1);
        send_body(1'b1, -32'sh10000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 1'b1);
        send_body(1'b1, 32'sh10000, 32'sh80000000, 0, 0, 32'sh7FFFFFFF, 0, 0,
                  31'h7FFFFFFF, 1'b1);
        send_body(1'b1, 32'sh7FFFFFFF, 0, 0, 0, 32'sh40000000, 0, 0, 31'h7FFFFFFF, 1'b1);
        drain_pipe();

        // Random segments, each under its own register setting
        for (int seg = 0; seg < 8; seg++) begin
            case (seg)
                0: begin mode = MODE_LINEAR; radius = RADIUS_RST; scale = SCALE_RST; end
                1: begin mode = MODE_SQUARE; radius = 31'h7FFFFFFF; scale = 16'hFFFF; end
                2: begin mode = 2'd3; radius = '0; scale = '0; end
                3: begin mode = MODE_CONST; radius = 31'd1; scale = 16'd1; end
                default: begin
                    mode   = 2'($urandom_range(0, 3));
                    radius = $urandom_range(1) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20));
                    scale  = 16'($urandom());
                end
            endcase
            tx_idle_pct = seg < 3 ? 12 : (seg < 6 ? 79 : 0);
            rx_idle_pct = seg < 3 ? 79 : (seg < 6 ? 12 : 0);
            write_regs(mode, radius, scale);
            repeat (250) send_random_body(radius);
            drain_pipe();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/rff_pkg.sv
rtl/core/rff_front.sv
rtl/core/rff_sqrt.sv
rtl/core/rff_div.sv
rtl/core/radial_force_falloff.sv
rtl/core/rff_checker.sv
verif/rff_force_checker.sv
verif/radial_force_falloff_tb.sv
